>>> hdl/adsr_pkg.sv
// Shared constants, register codes and helpers of the linear ADSR amplitude unit.
package adsr_pkg;

  // Default widths of time values and of Q1.15 levels.
  localparam int TIME_BITS_DEF  = 32;
  localparam int LEVEL_BITS_DEF = 16;

  // Width of the register index on the configuration channel.
  localparam int CFG_IDX_BITS = 3;

  // Reset values of the configuration registers.
  localparam int ATTACK_RESET  = 4410;
  localparam int DECAY_RESET   = 4410;
  localparam int SUSTAIN_RESET = 32768;
  localparam int RELEASE_RESET = 8820;
  localparam int START_RESET   = 32768;

  // Register indexes of the configuration channel.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_START   = 3'd4
  } cfg_reg_e;

  // Clock edges from the edge that takes an item to the edge at which its
  // result transfers.
  function automatic int result_latency(input int level_bits);
    return 2 * level_bits + 9;
  endfunction

endpackage

>>> hdl/adsr_muldiv.sv
// Pipelined floor(a * b / c) unit with a <= c, one quotient bit per stage.
module adsr_muldiv #(
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16,
  parameter int SIDE_BITS  = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  logic [TIME_BITS-1:0]  a_i,
  input  logic [LEVEL_BITS-1:0] b_i,
  input  logic [TIME_BITS-1:0]  c_i,
  input  logic [SIDE_BITS-1:0]  side_i,
  output logic                  out_vld_o,
  output logic [LEVEL_BITS-1:0] q_o,
  output logic [SIDE_BITS-1:0]  side_o
);

  localparam int LoBits   = (TIME_BITS + 1) / 2;
  localparam int HiBits   = TIME_BITS - LoBits;
  localparam int ProdBits = TIME_BITS + LEVEL_BITS;

  // Partial product stage: the multiplicand is split in two halves.
  logic                         pp_vld_q;
  logic [LoBits+LEVEL_BITS-1:0] pp_lo_q;
  logic [HiBits+LEVEL_BITS-1:0] pp_hi_q;
  logic [TIME_BITS-1:0]         pp_c_q;
  logic [SIDE_BITS-1:0]         pp_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
    end else begin
      pp_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_lo_q   <= a_i[LoBits-1:0] * b_i;
    pp_hi_q   <= a_i[TIME_BITS-1:LoBits] * b_i;
    pp_c_q    <= c_i;
    pp_side_q <= side_i;
  end

  // Division stages. Entry 0 holds the full product, entry k+1 the state
  // after quotient bit k has been decided.
  logic                  vld_q  [LEVEL_BITS+1];
  logic [TIME_BITS-1:0]  rem_q  [LEVEL_BITS+1];
  logic [LEVEL_BITS-1:0] lo_q   [LEVEL_BITS+1];
  logic [LEVEL_BITS-1:0] quo_q  [LEVEL_BITS+1];
  logic [TIME_BITS-1:0]  c_q    [LEVEL_BITS+1];
  logic [SIDE_BITS-1:0]  side_q [LEVEL_BITS+1];

  logic [ProdBits-1:0] prod_d;

  assign prod_d = ProdBits'(pp_lo_q) + (ProdBits'(pp_hi_q) << LoBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= pp_vld_q;
    end
  end

  // Since a <= c the product's upper part is already below c.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= prod_d[ProdBits-1:LEVEL_BITS];
    lo_q[0]   <= prod_d[LEVEL_BITS-1:0];
    quo_q[0]  <= '0;
    c_q[0]    <= pp_c_q;
    side_q[0] <= pp_side_q;
  end

  for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_div
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;
    logic                 ge;

    assign trial = {rem_q[k], lo_q[k][LEVEL_BITS-1]};
    assign ge    = trial >= {1'b0, c_q[k]};
    assign diff  = trial - {1'b0, c_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      lo_q[k+1]   <= {lo_q[k][LEVEL_BITS-2:0], 1'b0};
      quo_q[k+1]  <= {quo_q[k][LEVEL_BITS-2:0], ge};
      c_q[k+1]    <= c_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign out_vld_o = vld_q[LEVEL_BITS];
  assign q_o       = quo_q[LEVEL_BITS];
  assign side_o    = side_q[LEVEL_BITS];

endmodule

>>> hdl/adsr_envelope_amplitude_unit.sv
// Top level of the linear ADSR amplitude unit: configuration, phase selection, two divide pipes.
// Throughput: one item per clock cycle; busy_o stays low, so start_i may be high every cycle.
// Each item passes through two divide pipelines of one quotient bit per stage each.
// Reset: rst_ni clears every valid bit at once and loads the configuration reset values;
// the configuration channel is always ready and the receiver of results cannot stall.
module adsr_envelope_amplitude_unit #(
  parameter int   TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
  parameter int   LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF,
  localparam int  CfgBits    = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item channel.
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [TIME_BITS-1:0]            now_tick_i,
  input  logic [TIME_BITS-1:0]            key_on_tick_i,
  input  logic [TIME_BITS-1:0]            key_off_tick_i,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]              cfg_data_i,
  // Result strobe and payload.
  output logic                            valid_o,
  output logic [LEVEL_BITS-1:0]           level_o,
  output logic                            silent_o
);

  import adsr_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int LB = LEVEL_BITS;

  // Sideband through the first divide pipe: held, release done, subtract, base, elapsed.
  localparam int Side1Bits = TB + LB + 3;

  typedef struct packed {
    logic          held;
    logic          rel_done;
    logic          sub;
    logic [LB-1:0] base;
    logic [TB-1:0] elapsed;
  } side1_t;

  // The unit never stalls: every cycle can take an item and a configuration write.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty;
  // the user keeps to this, the block does not enforce it. The stages below read
  // these registers directly instead of carrying a copy along with each item.
  // ---------------------------------------------------------------------------
  logic [TB-1:0] attack_q;
  logic [TB-1:0] decay_q;
  logic [LB-1:0] sustain_q;
  logic [TB-1:0] release_q;
  logic [LB-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= TB'(ATTACK_RESET);
      decay_q   <= TB'(DECAY_RESET);
      sustain_q <= LB'(SUSTAIN_RESET);
      release_q <= TB'(RELEASE_RESET);
      start_q   <= LB'(START_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ATTACK:  attack_q  <= cfg_data_i[TB-1:0];
        REG_DECAY:   decay_q   <= cfg_data_i[TB-1:0];
        REG_SUSTAIN: sustain_q <= cfg_data_i[LB-1:0];
        REG_RELEASE: release_q <= cfg_data_i[TB-1:0];
        REG_START:   start_q   <= cfg_data_i[LB-1:0];
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  // Values derived from the configuration, registered to keep the adder out
  // of the phase-selection path. They settle in the cycle after a write lands,
  // well before an item that follows the write reaches the stage that reads them.
  logic [TB:0]   attack_decay_q;
  logic [LB-1:0] gap_q;
  logic          sus_ge_q;

  always_ff @(posedge clk_i) begin
    attack_decay_q <= {1'b0, attack_q} + {1'b0, decay_q};
    sus_ge_q       <= sustain_q >= start_q;
    gap_q          <= (sustain_q >= start_q) ? (sustain_q - start_q) : (start_q - sustain_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register.
  // ---------------------------------------------------------------------------
  logic          s1_vld_q;
  logic [TB-1:0] s1_now_q;
  logic [TB-1:0] s1_on_q;
  logic [TB-1:0] s1_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_now_q <= now_tick_i;
    s1_on_q  <= key_on_tick_i;
    s1_off_q <= key_off_tick_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: time differences. A held key measures its lifetime up to now; a
  // released key measures it up to key-off and also the time since key-off.
  // A held key seen before its key-on time is flagged and ends at level zero.
  // ---------------------------------------------------------------------------
  logic          s2_vld_q;
  logic          s2_held_q;
  logic          s2_early_q;
  logic [TB-1:0] s2_life_q;
  logic [TB-1:0] s2_elapsed_q;

  logic          s2_held_d;

  assign s2_held_d = s1_on_q > s1_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_held_q    <= s2_held_d;
    s2_early_q   <= s2_held_d && (s1_now_q < s1_on_q);
    s2_life_q    <= s2_held_d ? (s1_now_q - s1_on_q) : (s1_off_q - s1_on_q);
    s2_elapsed_q <= (s1_now_q > s1_off_q) ? (s1_now_q - s1_off_q) : '0;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: phase selection and operands of the first divide pipe.
  // Attack ramps from zero toward the start level, decay moves from the start
  // level toward sustain, and sustain needs no division at all: there the
  // pipe gets a zero multiplicand and a divisor of one, and the base carries
  // the level. A zero-length attack or decay never selects its phase.
  // ---------------------------------------------------------------------------
  logic          in_attack;
  logic          in_decay;
  logic [TB-1:0] decay_time;
  logic          rel_done;

  logic [TB-1:0] m1_a_d;
  logic [LB-1:0] m1_b_d;
  logic [TB-1:0] m1_c_d;
  side1_t        m1_side_d;

  logic          m1_vld_q;
  logic [TB-1:0] m1_a_q;
  logic [LB-1:0] m1_b_q;
  logic [TB-1:0] m1_c_q;
  side1_t        m1_side_q;

  assign in_attack  = (attack_q != '0) && (s2_life_q <= attack_q);
  assign in_decay   = !in_attack && (decay_q != '0) && ({1'b0, s2_life_q} <= attack_decay_q);
  assign decay_time = s2_life_q - attack_q;
  // Release is over once the time since key-off reaches the release length;
  // a zero release length ends it at once.
  assign rel_done   = (release_q == '0) || (s2_elapsed_q >= release_q);

  always_comb begin
    m1_side_d.held     = s2_held_q;
    m1_side_d.rel_done = rel_done;
    m1_side_d.elapsed  = s2_elapsed_q;
    m1_side_d.sub      = 1'b0;
    m1_side_d.base     = '0;
    m1_a_d             = '0;
    m1_b_d             = '0;
    m1_c_d             = TB'(1);
    if (s2_early_q) begin
      // Before key-on the clamped ramp is zero: all defaults hold.
    end else if (in_attack) begin
      m1_a_d = s2_life_q;
      m1_b_d = start_q;
      m1_c_d = attack_q;
    end else if (in_decay) begin
      m1_a_d         = decay_time;
      m1_b_d         = gap_q;
      m1_c_d         = decay_q;
      m1_side_d.base = start_q;
      m1_side_d.sub  = !sus_ge_q;
    end else begin
      m1_side_d.base = sustain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_a_q    <= m1_a_d;
    m1_b_q    <= m1_b_d;
    m1_c_q    <= m1_c_d;
    m1_side_q <= m1_side_d;
  end

  // First divide pipe: the step of the attack or decay ramp.
  logic          d1_vld;
  logic [LB-1:0] d1_q;
  side1_t        d1_side;

  adsr_muldiv #(
    .TIME_BITS  (TB),
    .LEVEL_BITS (LB),
    .SIDE_BITS  (Side1Bits)
  ) u_held_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (m1_vld_q),
    .a_i       (m1_a_q),
    .b_i       (m1_b_q),
    .c_i       (m1_c_q),
    .side_i    (m1_side_q),
    .out_vld_o (d1_vld),
    .q_o       (d1_q),
    .side_o    (d1_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: level while held, then operands of the release division.
  // A held key passes its level straight through with a zero step. A released
  // key whose release is over passes zero. Otherwise the release ramp takes
  // floor(elapsed * level / release) off the level reached at key-off.
  // ---------------------------------------------------------------------------
  logic [LB-1:0] held_level;

  logic [TB-1:0] m2_a_d;
  logic [LB-1:0] m2_b_d;
  logic [TB-1:0] m2_c_d;
  logic [LB-1:0] m2_base_d;

  logic          m2_vld_q;
  logic [TB-1:0] m2_a_q;
  logic [LB-1:0] m2_b_q;
  logic [TB-1:0] m2_c_q;
  logic [LB-1:0] m2_base_q;

  assign held_level = d1_side.sub ? (d1_side.base - d1_q) : (d1_side.base + d1_q);

  always_comb begin
    m2_a_d    = '0;
    m2_b_d    = '0;
    m2_c_d    = TB'(1);
    m2_base_d = held_level;
    if (!d1_side.held) begin
      if (d1_side.rel_done) begin
        m2_base_d = '0;
      end else begin
        m2_a_d = d1_side.elapsed;
        m2_b_d = held_level;
        m2_c_d = release_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else begin
      m2_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_a_q    <= m2_a_d;
    m2_b_q    <= m2_b_d;
    m2_c_q    <= m2_c_d;
    m2_base_q <= m2_base_d;
  end

  // Second divide pipe: the step of the release ramp.
  logic          d2_vld;
  logic [LB-1:0] d2_q;
  logic [LB-1:0] d2_base;

  adsr_muldiv #(
    .TIME_BITS  (TB),
    .LEVEL_BITS (LB),
    .SIDE_BITS  (LB)
  ) u_release_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (m2_vld_q),
    .a_i       (m2_a_q),
    .b_i       (m2_b_q),
    .c_i       (m2_c_q),
    .side_i    (m2_base_q),
    .out_vld_o (d2_vld),
    .q_o       (d2_q),
    .side_o    (d2_base)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: output register. The step never exceeds the base, so the
  // difference is never negative. The strobe is high for one cycle per item.
  // ---------------------------------------------------------------------------
  logic          valid_q;
  logic [LB-1:0] level_q;
  logic          silent_q;
  logic [LB-1:0] level_d;

  assign level_d = d2_base - d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    silent_q <= level_d == '0;
  end

  assign valid_o  = valid_q;
  assign level_o  = level_q;
  assign silent_o = silent_q;

endmodule

>>> hdl/adsr_checker.sv
// Port-level assertions of the linear ADSR amplitude unit, bound to its top level.
module adsr_checker #(
  parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
  parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  cfg_ready_o,
  input logic [TIME_BITS-1:0]  now_tick_i,
  input logic [TIME_BITS-1:0]  key_on_tick_i,
  input logic [TIME_BITS-1:0]  key_off_tick_i,
  input logic                  valid_o,
  input logic [LEVEL_BITS-1:0] level_o,
  input logic                  silent_o
);

  import adsr_pkg::*;

  localparam int Lat     = result_latency(LEVEL_BITS);
  localparam int CntBits = $clog2(Lat + 1);

  // Cycles since reset was released, saturating at the latency, so that the
  // history checks only look back over time spent out of reset.
  logic [CntBits-1:0] up_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_cnt_q <= '0;
    end else if (up_cnt_q != CntBits'(Lat)) begin
      up_cnt_q <= up_cnt_q + CntBits'(1);
    end
  end

  // The unit is fully pipelined: it never holds off items or writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o && cfg_ready_o)
    else $error("unit refused an item or a configuration write");

  // Exactly one result per taken item, after the delay given by result_latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_cnt_q == CntBits'(Lat)) |->
      (valid_o == $past(start_i && !busy_o && rst_ni, Lat)))
    else $error("result strobe does not match the item taken earlier");

  // The silent flag marks exactly a zero level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (silent_o == (level_o == '0)))
    else $error("silent flag disagrees with the level");

  // A held key evaluated before its key-on time gives a silent zero level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((up_cnt_q == CntBits'(Lat)) &&
     $past(start_i && !busy_o && rst_ni && (key_on_tick_i > key_off_tick_i) &&
           (now_tick_i < key_on_tick_i), Lat)) |->
      (valid_o && (level_o == '0) && silent_o))
    else $error("level before key-on is not zero");

endmodule

bind adsr_envelope_amplitude_unit adsr_checker #(
  .TIME_BITS  (TIME_BITS),
  .LEVEL_BITS (LEVEL_BITS)
) u_adsr_checker (.*);
